>>> hdl/cesd_pkg.sv
// Shared types, character constants and helper functions of the escape decoder.
package cesd_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // Control codes produced by the letter escapes
  localparam logic [7:0] CC_BEL = 8'd7;
  localparam logic [7:0] CC_TAB = 8'd9;
  localparam logic [7:0] CC_LF  = 8'd10;
  localparam logic [7:0] CC_VT  = 8'd11;
  localparam logic [7:0] CC_FF  = 8'd12;
  localparam logic [7:0] CC_CR  = 8'd13;

  localparam int unsigned MAX_RESULTS = 3;

  typedef enum logic [4:0] {
    MODE_TEXT     = 5'b00001,
    MODE_ESC      = 5'b00010,
    MODE_HEXSTART = 5'b00100,
    MODE_HEX      = 5'b01000,
    MODE_OCT      = 5'b10000
  } mode_t;

  // Results caused by one input character, in emission order
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
    logic [MAX_RESULTS-1:0]       ends;
  } bundle_t;

  // Append one result to a bundle
  function automatic bundle_t push(bundle_t b, logic [7:0] v, logic e);
    bundle_t r;
    r = b;
    r.bytes[b.cnt] = v;
    r.ends[b.cnt]  = e;
    r.cnt          = b.cnt + 2'd1;
    return r;
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c inside {[CH_0:CH_7]});
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c inside {[CH_0:CH_9], [CH_UA:CH_UF], [CH_LA:CH_LF]});
  endfunction

  // Digit value of a hex character already known to be one
  function automatic logic [3:0] hex_val(logic [7:0] c);
    return (c inside {[CH_0:CH_9]}) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] map_escape(logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_N:    r = CC_LF;
      CH_LA:   r = CC_BEL;
      CH_V:    r = CC_VT;
      CH_R:    r = CC_CR;
      CH_T:    r = CC_TAB;
      CH_LF:   r = CC_FF;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/c_escape_sequence_decoder.sv
// Top level of the C string escape decoder: front parser, bundle queue, result serializer.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+-----------------------------------
//   input   | in        | in_valid/in_stall  | ch[7:0], last
//   output  | out       | out_valid/out_stall| out_byte[7:0], string_end, run_last
//
// Flow: one character is taken per cycle while in_stall is low; the front parses it
// in that cycle and queues the bundle of one to three results it causes, or nothing
// if it causes none. The back end hands out one result word per cycle while out_stall
// is low, so the sustained rate is set by the serializer. A result word reaches the
// outputs through the queue entry and then the back end's current-bundle register.
// Stalls: in_stall rises only while the QUEUE_DEPTH-entry bundle queue is full.
// Reset: rst (synchronous) returns the parser to text mode and empties the queue.
module c_escape_sequence_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       string_end,
  output logic       run_last
);

  cesd_pkg::bundle_t front_bundle, q_data;
  logic              accept, push, q_full, q_empty, q_pop;

  // Hold the input while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  cesd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (ch),
    .last   (last),
    .push   (push),
    .bundle (front_bundle)
  );

  cesd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_bundle),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  cesd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .string_end (string_end),
    .run_last   (run_last)
  );

endmodule

>>> hdl/cesd_front.sv
// Front end: parses each character and produces the bundle of results it causes.
module cesd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        ch,
  input  logic              last,
  output logic              push,
  output cesd_pkg::bundle_t bundle
);

  cesd_pkg::mode_t mode, mode_next;
  logic [7:0]      digit_value, digit_value_next;

  always_comb begin
    cesd_pkg::bundle_t b;
    logic              ended;
    logic              do_text;
    b                = '0;
    ended            = 1'b0;
    do_text          = 1'b0;
    mode_next        = mode;
    digit_value_next = digit_value;

    case (mode)
      cesd_pkg::MODE_ESC: begin
        if (ch == cesd_pkg::CH_NUL) begin
          // trailing backslash: drop it, close the string
          b                = cesd_pkg::push(b, cesd_pkg::CH_NUL, 1'b1);
          mode_next        = cesd_pkg::MODE_TEXT;
          digit_value_next = '0;
          ended            = 1'b1;
        end else if (ch == cesd_pkg::CH_X) begin
          mode_next = cesd_pkg::MODE_HEXSTART;
        end else if (cesd_pkg::is_oct(ch)) begin
          digit_value_next = {5'd0, ch[2:0]};
          mode_next        = cesd_pkg::MODE_OCT;
        end else begin
          b         = cesd_pkg::push(b, cesd_pkg::map_escape(ch), 1'b0);
          mode_next = cesd_pkg::MODE_TEXT;
        end
      end
      cesd_pkg::MODE_HEXSTART: begin
        if (cesd_pkg::is_hex(ch)) begin
          digit_value_next = {4'd0, cesd_pkg::hex_val(ch)};
          mode_next        = cesd_pkg::MODE_HEX;
        end else begin
          b       = cesd_pkg::push(b, cesd_pkg::CH_X, 1'b0);
          do_text = 1'b1;
        end
      end
      cesd_pkg::MODE_HEX: begin
        if (cesd_pkg::is_hex(ch)) begin
          digit_value_next = {digit_value[3:0], cesd_pkg::hex_val(ch)};
        end else begin
          b                = cesd_pkg::push(b, digit_value, 1'b0);
          digit_value_next = '0;
          do_text          = 1'b1;
        end
      end
      cesd_pkg::MODE_OCT: begin
        if (cesd_pkg::is_oct(ch)) begin
          digit_value_next = {digit_value[4:0], ch[2:0]};
        end else begin
          b                = cesd_pkg::push(b, digit_value, 1'b0);
          digit_value_next = '0;
          do_text          = 1'b1;
        end
      end
      default: begin
        do_text = 1'b1;
      end
    endcase

    // handle the character as plain text
    if (do_text) begin
      mode_next = cesd_pkg::MODE_TEXT;
      if (ch == cesd_pkg::CH_NUL) begin
        b                = cesd_pkg::push(b, cesd_pkg::CH_NUL, 1'b1);
        digit_value_next = '0;
        ended            = 1'b1;
      end else if (ch == cesd_pkg::CH_BSLASH) begin
        mode_next = cesd_pkg::MODE_ESC;
      end else begin
        b = cesd_pkg::push(b, ch, 1'b0);
      end
    end

    // length limit reached: flush anything pending, then terminate
    if (last && !ended) begin
      if (mode_next == cesd_pkg::MODE_HEX || mode_next == cesd_pkg::MODE_OCT) begin
        b = cesd_pkg::push(b, digit_value_next, 1'b0);
      end else if (mode_next == cesd_pkg::MODE_HEXSTART) begin
        b = cesd_pkg::push(b, cesd_pkg::CH_X, 1'b0);
      end
      b                = cesd_pkg::push(b, cesd_pkg::CH_NUL, 1'b1);
      mode_next        = cesd_pkg::MODE_TEXT;
      digit_value_next = '0;
    end

    bundle = b;
  end

  assign push = accept && (bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= cesd_pkg::MODE_TEXT;
      digit_value <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      digit_value <= digit_value_next;
    end
  end

endmodule

>>> hdl/cesd_queue.sv
// Short register queue of result bundles between front and back end.
module cesd_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cesd_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output cesd_pkg::bundle_t pop_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cesd_pkg::bundle_t entries [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/cesd_back.sv
// Back end: takes bundles from the queue and delivers their results one word a cycle while out_stall is low.
module cesd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cesd_pkg::bundle_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              string_end,
  output logic              run_last
);

  cesd_pkg::bundle_t cur;
  logic              cur_valid;
  logic [1:0]        idx;
  logic              out_fire, done;

  assign run_last  = (idx == cur.cnt - 2'd1);
  assign out_fire  = cur_valid && !out_stall;
  assign done      = out_fire && run_last;
  assign q_pop     = !q_empty && (!cur_valid || done);
  assign out_valid = cur_valid;
  assign out_byte  = cur.bytes[idx];
  assign string_end = cur.ends[idx];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (out_fire) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
